// File: rtl/shph_pkg.sv
`timescale 1ns / 1ps

package shph_pkg;

  localparam int HALF_BITS   = 64;
  localparam int IDX_W       = 7;
  localparam int VALUE_W     = 48;
  localparam int QUEUE_DEPTH = 4;

  // Request kind, carried on in_tuser.
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  // One result, compared in the lowest bits.
  typedef struct packed {
    logic [VALUE_W-1:0] bin_value;
    logic [IDX_W-1:0]   max_shared;
    logic               order_fault;
    logic [IDX_W-1:0]   shared_bits;
    logic               compared;
  } result_t;

  // Front stage to bin update stage.
  typedef struct packed {
    logic             is_read;
    logic             rd_ok;
    logic             compared;
    logic [IDX_W-1:0] shared_bits;
    logic             order_fault;
    logic [IDX_W-1:0] max_shared;
    logic [IDX_W-1:0] addr;
  } stage_t;

  // Leading zeros of a nonzero word; all-zero input gives 63.
  function automatic logic [5:0] lzc64(input logic [HALF_BITS-1:0] v);
    logic [HALF_BITS-1:0] x;
    logic [5:0]           n;
    x = v;
    n = '0;
    if (x[63:32] == 32'd0) begin
      n[5] = 1'b1;
      x = {x[31:0], 32'd0};
    end
    if (x[63:48] == 16'd0) begin
      n[4] = 1'b1;
      x = {x[47:0], 16'd0};
    end
    if (x[63:56] == 8'd0) begin
      n[3] = 1'b1;
      x = {x[55:0], 8'd0};
    end
    if (x[63:60] == 4'd0) begin
      n[2] = 1'b1;
      x = {x[59:0], 4'd0};
    end
    if (x[63:62] == 2'd0) begin
      n[1] = 1'b1;
      x = {x[61:0], 2'd0};
    end
    if (x[63] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

endpackage

// File: rtl/shph_ram.sv
`timescale 1ns / 1ps

module shph_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/shph_front.sv
`timescale 1ns / 1ps

module shph_front #(
  parameter int NUM_BINS = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic                                cmd,
  input  logic [shph_pkg::HALF_BITS-1:0]      hash_high,
  input  logic [shph_pkg::HALF_BITS-1:0]      hash_low,
  input  logic [shph_pkg::IDX_W-1:0]          bin_index,
  output logic [shph_pkg::IDX_W-1:0]          rd_addr,
  output logic                                st_valid,
  output shph_pkg::stage_t                    st
);

  localparam logic [shph_pkg::IDX_W-1:0] BinLast = shph_pkg::IDX_W'(NUM_BINS - 1);
  localparam logic [shph_pkg::IDX_W:0]   BinCnt  = (shph_pkg::IDX_W + 1)'(NUM_BINS);

  logic [shph_pkg::HALF_BITS-1:0] prev_high_r, prev_high_nxt;
  logic [shph_pkg::HALF_BITS-1:0] prev_low_r, prev_low_nxt;
  logic                           have_r, have_nxt;
  logic                           fault_r, fault_nxt;
  logic [shph_pkg::IDX_W-1:0]     max_r, max_nxt;
  logic                           st_valid_r;
  shph_pkg::stage_t               st_r, st_nxt;

  logic [shph_pkg::HALF_BITS-1:0] x_high, x_low;
  logic                           high_eq, equal, ordered, push, do_cmp;
  logic [5:0]                     lz;
  logic [shph_pkg::IDX_W-1:0]     shared, bin;
  logic                           rd_ok;

  always_comb begin
    x_high  = prev_high_r ^ hash_high;
    x_low   = prev_low_r ^ hash_low;
    high_eq = (x_high == '0);
    equal   = high_eq && (x_low == '0);
    ordered = {prev_high_r, prev_low_r} <= {hash_high, hash_low};
    lz      = shph_pkg::lzc64(high_eq ? x_low : x_high);
    shared  = equal ? '0 : {high_eq, lz};
    bin     = ({1'b0, shared} >= BinCnt) ? BinLast : shared;
    rd_ok   = {1'b0, bin_index} < BinCnt;
    push    = accept && (cmd == shph_pkg::CMD_PUSH) && !fault_r;
    do_cmp  = push && have_r && ordered;
    rd_addr = (cmd == shph_pkg::CMD_READ) ? bin_index : bin;
  end

  always_comb begin
    prev_high_nxt = prev_high_r;
    prev_low_nxt  = prev_low_r;
    have_nxt      = have_r;
    fault_nxt     = fault_r;
    max_nxt       = max_r;
    if (push) begin
      have_nxt = 1'b1;
      if (!have_r || ordered) begin
        prev_high_nxt = hash_high;
        prev_low_nxt  = hash_low;
      end else begin
        fault_nxt = 1'b1;
      end
    end
    if (do_cmp && (shared > max_r)) begin
      max_nxt = shared;
    end
    st_nxt.is_read     = (cmd == shph_pkg::CMD_READ);
    st_nxt.rd_ok       = rd_ok;
    st_nxt.compared    = do_cmp;
    st_nxt.shared_bits = do_cmp ? shared : '0;
    st_nxt.order_fault = fault_nxt;
    st_nxt.max_shared  = max_nxt;
    st_nxt.addr        = rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_high_r <= '0;
      prev_low_r  <= '0;
      have_r      <= 1'b0;
      fault_r     <= 1'b0;
      max_r       <= '0;
      st_valid_r  <= 1'b0;
    end else begin
      prev_high_r <= prev_high_nxt;
      prev_low_r  <= prev_low_nxt;
      have_r      <= have_nxt;
      fault_r     <= fault_nxt;
      max_r       <= max_nxt;
      st_valid_r  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r <= st_nxt;
    end
  end

  assign st_valid = st_valid_r;
  assign st       = st_r;

endmodule

// File: rtl/shph_bins.sv
`timescale 1ns / 1ps

module shph_bins #(
  parameter int NUM_BINS    = 128,
  parameter int COUNT_WIDTH = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [shph_pkg::IDX_W-1:0] rd_addr,
  input  logic                       st_valid,
  input  shph_pkg::stage_t           st,
  output shph_pkg::result_t          res
);

  localparam int AW = $clog2(NUM_BINS);

  logic [NUM_BINS-1:0]        valid_r, valid_nxt;
  logic                       vld_r;
  logic                       fwd_v_r;
  logic [shph_pkg::IDX_W-1:0] fwd_addr_r;
  logic [COUNT_WIDTH-1:0]     fwd_data_r;
  logic [COUNT_WIDTH-1:0]     dout, cur, cnt_nxt;
  logic                       wen;
  logic [63:0]                cur_wide;

  shph_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (wen),
    .waddr (st.addr[AW-1:0]),
    .wdata (cnt_nxt),
    .re    (rd_en),
    .raddr (rd_addr[AW-1:0]),
    .rdata (dout)
  );

  always_comb begin
    // last cycle's write is not yet visible in the RAM read data
    if (fwd_v_r && (fwd_addr_r == st.addr)) begin
      cur = fwd_data_r;
    end else if (vld_r) begin
      cur = dout;
    end else begin
      cur = '0;
    end
    cnt_nxt   = (cur == '1) ? cur : cur + COUNT_WIDTH'(1);
    wen       = st_valid && st.compared;
    valid_nxt = valid_r;
    if (wen) begin
      valid_nxt[st.addr[AW-1:0]] = 1'b1;
    end
    cur_wide        = 64'(cur);
    res.compared    = st.compared;
    res.shared_bits = st.shared_bits;
    res.order_fault = st.order_fault;
    res.max_shared  = st.max_shared;
    res.bin_value   = (st.is_read && st.rd_ok) ? cur_wide[shph_pkg::VALUE_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fwd_v_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      fwd_v_r <= wen;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_r <= valid_r[rd_addr[AW-1:0]];
    end
    if (wen) begin
      fwd_addr_r <= st.addr;
      fwd_data_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/shph_outq.sv
`timescale 1ns / 1ps

module shph_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  shph_pkg::result_t push_data,
  input  logic              inflight,
  output logic              space_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output shph_pkg::result_t out_data
);

  localparam int PW = $clog2(shph_pkg::QUEUE_DEPTH);
  localparam int CW = PW + 1;
  localparam logic [CW-1:0] Depth = CW'(shph_pkg::QUEUE_DEPTH);

  shph_pkg::result_t q_r [shph_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pop;

  always_comb begin
    pop     = out_valid && out_ready;
    wp_nxt  = push ? wp_r + PW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_data;
    end
  end

  // reserve a slot for the request still in the bin stage
  assign space_ok  = (cnt_r + CW'(inflight)) < Depth;
  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rp_r];

endmodule

// File: rtl/sorted_hash_prefix_histogram.sv
`timescale 1ns / 1ps

// Shared-prefix histogram over a sorted stream of 128-bit hashes.
// Input channel (in_*): one request per transfer. in_tuser = 0 pushes the
// hash in in_tdata, in_tuser = 1 reads histogram bin in_tdata[134:128].
// Output channel (out_*): exactly one result per request, in request order:
// compared flag, shared bit count, sticky order fault, running maximum and,
// for reads, the bin count.
// Throughput: one request per cycle while in_tready is high. A request's result
// passes the front stage register and the result queue before out_*. The hash compare
// and leading-zero count sit in the accept cycle because the next hash is
// compared against this one; the bin read-modify-write uses one RAM with
// registered read, and a write-to-read bypass covers back-to-back hits.
// A four-entry result queue absorbs receiver stalls; in_tready drops only
// when the queue plus the request in flight fill it.
// Reset (rst_n low, synchronous) clears the stored hash, fault, maximum and
// the per-bin valid flags, so every bin reads zero right after reset with
// no clearing pass; the output channel comes up empty.
module sorted_hash_prefix_histogram #(
  parameter int NUM_BINS    = 128,
  parameter int COUNT_WIDTH = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // hash_high[63:0], hash_low[127:64], bin_index[134:128]
  input  logic         in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata   // compared[0], shared_bits[7:1], order_fault[8],
                                   // max_shared[15:9], bin_value[63:16]
);

  logic                       accept;
  logic [shph_pkg::IDX_W-1:0] rd_addr;
  logic                       st_valid;
  shph_pkg::stage_t           st;
  shph_pkg::result_t          res, q_out;
  logic                       space_ok;

  assign accept = in_tvalid && in_tready;

  shph_front #(
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd       (in_tuser),
    .hash_high (in_tdata[63:0]),
    .hash_low  (in_tdata[127:64]),
    .bin_index (in_tdata[134:128]),
    .rd_addr   (rd_addr),
    .st_valid  (st_valid),
    .st        (st)
  );

  shph_bins #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_bins (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .st_valid (st_valid),
    .st       (st),
    .res      (res)
  );

  shph_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (st_valid),
    .push_data (res),
    .inflight  (st_valid),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_out)
  );

  assign in_tready = space_ok;
  assign out_tdata = q_out;

endmodule

// File: rtl/shph_checker.sv
`timescale 1ns / 1ps

module shph_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  logic       fault_r;
  logic [6:0] max_r;
  logic       out_acc;

  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= 1'b0;
      max_r   <= '0;
    end else if (out_acc) begin
      fault_r <= out_tdata[8];
      max_r   <= out_tdata[15:9];
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result channel not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && fault_r |-> out_tdata[8])
    else $error("order fault cleared");

  a_max_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> out_tdata[15:9] >= max_r)
    else $error("max shared decreased");

  a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] ? (out_tdata[63:16] == 48'd0) : (out_tdata[7:1] == 7'd0)))
    else $error("shared count on uncompared request or bin value on counted push");

endmodule

bind sorted_hash_prefix_histogram shph_checker u_shph_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int CALM_FROM      = 800;   // no idling from here on
  localparam int DRAIN_CYCLES   = 10;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata   = '0;
  logic         in_tuser   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;

  sorted_hash_prefix_histogram u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predicted histogram state
  logic [127:0] prev_hash;
  logic         have_prev;
  logic         order_fault_seen;
  logic [6:0]   top_shared;
  logic [47:0]  bin_counts [128];

  shph_pkg::result_t prefix_results_q [$];
  logic [127:0] walk_hash;
  bit           idling_on = 1'b1;
  int           mismatch_count;
  int           results_checked;
  int           pairs_counted;
  int           reads_sent;
  int           quiet_cycles;
  int           stall_left;

  // leading bits two hashes share; equal hashes give 0
  function automatic logic [6:0] shared_prefix(logic [127:0] a, logic [127:0] b);
    logic [127:0] diff;
    diff = a ^ b;
    for (int i = 127; i >= 0; i--)
      if (diff[i]) return 7'(127 - i);
    return 7'd0;
  endfunction

  function automatic shph_pkg::result_t predict_prefix_result(shph_pkg::cmd_t cmd,
                                                              logic [127:0] hash,
                                                              logic [6:0] idx);
    shph_pkg::result_t r;
    r = '0;
    if (cmd == shph_pkg::CMD_READ) begin
      r.bin_value = bin_counts[idx];
    end else if (!order_fault_seen) begin
      if (!have_prev) begin
        prev_hash = hash;
        have_prev = 1'b1;
      end else if (hash < prev_hash) begin
        order_fault_seen = 1'b1;
      end else begin
        r.shared_bits = shared_prefix(prev_hash, hash);
        if (bin_counts[r.shared_bits] != '1)
          bin_counts[r.shared_bits] = bin_counts[r.shared_bits] + 48'd1;
        if (r.shared_bits > top_shared)
          top_shared = r.shared_bits;
        r.compared = 1'b1;
        prev_hash  = hash;
      end
    end
    r.order_fault = order_fault_seen;
    r.max_shared  = top_shared;
    return r;
  endfunction

  // next hash >= cur: first zero bit at or below pos is set, bits under it random
  function automatic logic [127:0] next_sorted_hash(logic [127:0] cur, int pos);
    logic [127:0] low_mask;
    logic [127:0] noise;
    int           q;
    q = pos;
    while (q >= 0 && cur[q]) q--;
    if (q < 0) return cur;
    noise    = {$urandom, $urandom, $urandom, $urandom};
    low_mask = (128'd1 << q) - 128'd1;
    return (cur & ~low_mask) | (128'd1 << q) | (noise & low_mask);
  endfunction

  function automatic logic [127:0] random_hash();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    $display("%0t: result %0d field %s: expected %0h, got %0h",
             $time, results_checked, field, want, got);
    mismatch_count++;
  endtask

  task automatic send_request(shph_pkg::cmd_t cmd, logic [127:0] hash, logic [6:0] idx);
    shph_pkg::result_t r;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, idx, hash[63:0], hash[127:64]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_prefix_result(cmd, hash, idx);
    prefix_results_q.push_back(r);
    if (r.compared) pairs_counted++;
    if (cmd == shph_pkg::CMD_READ) reads_sent++;
  endtask

  task automatic hold_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_hash(logic [127:0] hash);
    send_request(shph_pkg::CMD_PUSH, hash, 7'($urandom_range(0, 127)));
  endtask

  task automatic read_bin(logic [6:0] idx);
    send_request(shph_pkg::CMD_READ, random_hash(), idx);
  endtask

  task automatic test_reads_after_reset();
    send_request(shph_pkg::CMD_READ, '0, 7'd0);
    send_request(shph_pkg::CMD_READ, '1, 7'd127);
    read_bin(7'($urandom_range(1, 126)));
  endtask

  task automatic test_prefix_extremes();
    push_hash('0);                                 // first push is only stored
    push_hash('0);                                 // equal hashes count as 0
    push_hash({64'h0, 64'h8000_0000_0000_0000});   // high halves match: 64
    push_hash({64'h1, 64'h0});                     // 63
    push_hash({64'h8000_0000_0000_0000, 64'h0});   // top bit differs: 0
    read_bin(7'd0);
    read_bin(7'd63);
    read_bin(7'd64);
    send_request(shph_pkg::CMD_READ, '0, 7'd127);
    walk_hash = {64'h8000_0000_0000_0000, 64'h0};
  endtask

  // sorted stream whose shared prefix grows slowly, with reads mixed in
  task automatic test_random_sorted_stream();
    int pos_floor;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 2) begin
        hold_input();
        while (prefix_results_q.size() != 0) @(posedge clk);
      end
      if (k == CALM_FROM) idling_on = 1'b0;
      pos_floor = 127 - (k * 127) / (RANDOM_ITEMS - 1);
      if ($urandom_range(0, 3) == 0) begin
        read_bin(7'($urandom_range(0, 127)));
      end else begin
        if ($urandom_range(0, 9) != 0)
          walk_hash = next_sorted_hash(walk_hash, $urandom_range(pos_floor, 127));
        push_hash(walk_hash);
      end
    end
  endtask

  task automatic test_order_fault();
    if (walk_hash <= {{127{1'b1}}, 1'b0})
      push_hash({{127{1'b1}}, 1'b0});
    push_hash('1);                                 // last bit differs: 127
    push_hash('1);
    push_hash('0);                                 // smaller than predecessor
    for (int k = 0; k < 6; k++)
      push_hash(random_hash());                    // ignored after the fault
    push_hash('1);
    for (int b = 0; b < 128; b++)
      read_bin(7'(b));
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    shph_pkg::result_t want;
    shph_pkg::result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = shph_pkg::result_t'(out_tdata);
      if (prefix_results_q.size() == 0) begin
        report_mismatch("unrequested result", '0, out_tdata);
      end else begin
        want = prefix_results_q.pop_front();
        if (got.compared != want.compared)
          report_mismatch("compared", 64'(want.compared), 64'(got.compared));
        if (got.shared_bits != want.shared_bits)
          report_mismatch("shared_bits", 64'(want.shared_bits), 64'(got.shared_bits));
        if (got.order_fault != want.order_fault)
          report_mismatch("order_fault", 64'(want.order_fault), 64'(got.order_fault));
        if (got.max_shared != want.max_shared)
          report_mismatch("max_shared", 64'(want.max_shared), 64'(got.max_shared));
        if (got.bin_value != want.bin_value)
          report_mismatch("bin_value", 64'(want.bin_value), 64'(got.bin_value));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    prev_hash        = '0;
    have_prev        = 1'b0;
    order_fault_seen = 1'b0;
    top_shared       = '0;
    foreach (bin_counts[b]) bin_counts[b] = '0;
    walk_hash        = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reads_after_reset();
    test_prefix_extremes();
    test_random_sorted_stream();
    test_order_fault();

    hold_input();
    while (prefix_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d hash pairs counted, %0d bin reads",
             results_checked, pairs_counted, reads_sent);
    $display("Largest shared prefix %0d, sticky order fault %0b", top_shared,
             order_fault_seen);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
rtl/shph_pkg.sv
rtl/shph_ram.sv
rtl/shph_front.sv
rtl/shph_bins.sv
rtl/shph_outq.sv
rtl/sorted_hash_prefix_histogram.sv
rtl/shph_checker.sv
test/tb_top.sv
